// ===== sv/stn_pkg.sv =====
// Shared types, codes and the sequencer program of the spanning-tree node.
`default_nettype none
package stn_pkg;

  // Network size and field widths.
  localparam int NODES  = 8;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = 4;
  localparam int KIND_W = 2;
  localparam int UPC_W  = 4;
  localparam int CFG_W  = 8;
  localparam int CIDX_W = 2;

  localparam logic [NODES-1:0] NODE_ONE = {{(NODES-1){1'b0}}, 1'b1};

  // Message kinds and request types.
  localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_MSG   = 1'b1;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_NODE_ID = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ROOT    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MASK    = 2'd2;

  // Program addresses.
  localparam logic [UPC_W-1:0] A_WAIT     = 4'd0;
  localparam logic [UPC_W-1:0] A_DISPATCH = 4'd1;
  localparam logic [UPC_W-1:0] A_START    = 4'd2;
  localparam logic [UPC_W-1:0] A_ADOPT    = 4'd3;
  localparam logic [UPC_W-1:0] A_REJECT   = 4'd4;
  localparam logic [UPC_W-1:0] A_REPLY    = 4'd5;
  localparam logic [UPC_W-1:0] A_STATUS   = 4'd6;
  localparam logic [UPC_W-1:0] A_SCAN     = 4'd7;
  localparam logic [UPC_W-1:0] A_ACK      = 4'd8;

  // Jump conditions.
  typedef enum logic [1:0] {
    C_ACCEPT   = 2'd0,
    C_ALWAYS   = 2'd1,
    C_PEND_ZERO = 2'd2,
    C_DISPATCH = 2'd3
  } cond_t;

  // Result emission modes.
  typedef enum logic [1:0] {
    E_NONE      = 2'd0,
    E_MSG       = 2'd1,
    E_STATUS    = 2'd2,
    E_PROBE_BIT = 2'd3
  } emit_t;

  // Datapath updates.
  typedef enum logic [1:0] {
    U_NONE  = 2'd0,
    U_START = 2'd1,
    U_ADOPT = 2'd2,
    U_REPLY = 2'd3
  } upd_t;

  // Source of the last flag.
  typedef enum logic {
    L_ONE  = 1'b0,
    L_PEND = 1'b1
  } last_t;

  typedef struct packed {
    cond_t             cond;
    emit_t             emit;
    upd_t              upd;
    last_t             lsel;
    logic [KIND_W-1:0] kind;
    logic [UPC_W-1:0]  tgt;
    logic [UPC_W-1:0]  nxt;
  } ctrl_t;

  typedef struct packed {
    logic              req_type;
    logic [KIND_W-1:0] msg_kind;
    logic [NODE_W-1:0] msg_sender;
  } req_t;

  typedef struct packed {
    logic              msg_valid;
    logic [KIND_W-1:0] out_kind;
    logic [NODE_W-1:0] out_receiver;
    logic              last;
    logic              tree_done;
    logic [NODE_W-1:0] parent_index;
    logic [NODES-1:0]  child_set;
  } res_t;

  // The control store: one word per step.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_t w;
    w = '{cond: C_ALWAYS, emit: E_NONE, upd: U_NONE, lsel: L_ONE,
          kind: KIND_PROBE, tgt: A_WAIT, nxt: A_WAIT};
    case (addr)
      A_WAIT: begin
        w.cond = C_ACCEPT;
        w.tgt  = A_DISPATCH;
      end
      A_DISPATCH: w.cond = C_DISPATCH;
      A_START: begin
        w.upd  = U_START;
        w.cond = C_PEND_ZERO;
        w.tgt  = A_STATUS;
        w.nxt  = A_SCAN;
      end
      A_ADOPT: begin
        w.upd = U_ADOPT;
        w.tgt = A_ACK;
      end
      A_REJECT: begin
        w.emit = E_MSG;
        w.kind = KIND_REJECT;
      end
      A_REPLY: begin
        w.upd = U_REPLY;
        w.tgt = A_STATUS;
      end
      A_STATUS: w.emit = E_STATUS;
      A_SCAN: begin
        w.emit = E_PROBE_BIT;
        w.lsel = L_PEND;
        w.cond = C_PEND_ZERO;
        w.nxt  = A_SCAN;
      end
      A_ACK: begin
        w.emit = E_MSG;
        w.kind = KIND_ACK;
        w.lsel = L_PEND;
        w.cond = C_PEND_ZERO;
        w.nxt  = A_SCAN;
      end
      default: w.tgt = A_WAIT;
    endcase
    return w;
  endfunction

  // Number of set bits in a node mask.
  function automatic logic [CNT_W-1:0] count_ones(input logic [NODES-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int j = 0; j < NODES; j++) begin
      c = c + CNT_W'(m[j]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/stn_req_if.sv =====
// Request channel interface of the spanning-tree node.
`default_nettype none
interface stn_req_if;
  logic          valid;
  logic          ready;
  stn_pkg::req_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/stn_res_if.sv =====
// Result channel interface of the spanning-tree node.
`default_nettype none
interface stn_res_if;
  logic          valid;
  logic          ready;
  stn_pkg::res_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/spanning_tree_node_probe_echo_top.sv =====
// Spanning-tree node: microcoded sequencer over a small probe/ack/reject datapath.
// An item is taken in the wait step and decoded in the dispatch step; an ignored item or a reject
// emits one result, a reply updates the state and emits a status, a first probe emits an ack, and
// a start or first probe emits its probes as the scan step walks the node indexes, one index a
// cycle unless a probe waits for the result slot. Each item is finished before the next is taken.
// Reset (synchronous, rst high) clears the configuration, step counter, node state and result flag.
`default_nettype none
module spanning_tree_node_probe_echo_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  stn_req_if.sink                         req,
  stn_res_if.source                       res,
  input  wire logic                       cfg_we,
  input  wire logic [stn_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [stn_pkg::CFG_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [stn_pkg::NODE_W-1:0] node_id;
  logic [stn_pkg::NODE_W-1:0] root_node;
  logic [stn_pkg::NODES-1:0]  neighbor_mask;

  // Node state.
  logic                       has_parent;
  logic [stn_pkg::NODE_W-1:0] parent_reg;
  logic [stn_pkg::NODES-1:0]  child_bits;
  logic [stn_pkg::NODES-1:0]  nontree_bits;
  logic [stn_pkg::CNT_W-1:0]  reply_count;

  // Sequencer and working registers.
  logic [stn_pkg::UPC_W-1:0]  upc;
  logic [stn_pkg::UPC_W-1:0]  upc_next;
  stn_pkg::req_t              cur;
  logic [stn_pkg::NODES-1:0]  pending;
  logic [stn_pkg::NODES-1:0]  pending_next;
  logic [stn_pkg::NODE_W-1:0] scan_idx;
  logic                       res_valid;
  stn_pkg::res_t              res_data;

  stn_pkg::ctrl_t             ctrl;
  logic [stn_pkg::NODES-1:0]  nb;
  logic [stn_pkg::NODES-1:0]  sbit;
  logic [stn_pkg::NODES-1:0]  scan_bit;
  logic                       is_root;
  logic                       probe_ok;
  logic                       reply_ok;
  logic                       from_parent;
  logic [stn_pkg::UPC_W-1:0]  dispatch_tgt;
  logic                       emit_need;
  logic                       slot_free;
  logic                       adv;
  logic [stn_pkg::CNT_W-1:0]  need_all;
  logic [stn_pkg::CNT_W-1:0]  need;
  logic                       done_now;

  assign ctrl = stn_pkg::ucode(upc);

  // Neighbour set without the own bit, and decoded facts about the held item.
  assign nb          = neighbor_mask & ~(stn_pkg::NODE_ONE << node_id);
  assign sbit        = stn_pkg::NODE_ONE << cur.msg_sender;
  assign scan_bit    = stn_pkg::NODE_ONE << scan_idx;
  assign is_root     = (node_id == root_node);
  assign probe_ok    = (cur.req_type == stn_pkg::REQ_MSG) &&
                       (cur.msg_kind == stn_pkg::KIND_PROBE) &&
                       ((nb & sbit) != '0);
  assign from_parent = has_parent && !is_root && (cur.msg_sender == parent_reg);
  assign reply_ok    = (cur.req_type == stn_pkg::REQ_MSG) &&
                       ((cur.msg_kind == stn_pkg::KIND_ACK) ||
                        (cur.msg_kind == stn_pkg::KIND_REJECT)) &&
                       ((nb & sbit) != '0) && !from_parent &&
                       (((child_bits | nontree_bits) & sbit) == '0);

  // Multi-way jump target of the dispatch step.
  always_comb begin
    if ((cur.req_type == stn_pkg::REQ_START) && is_root && !has_parent) begin
      dispatch_tgt = stn_pkg::A_START;
    end else if (probe_ok && (is_root || has_parent)) begin
      dispatch_tgt = stn_pkg::A_REJECT;
    end else if (probe_ok) begin
      dispatch_tgt = stn_pkg::A_ADOPT;
    end else if (reply_ok) begin
      dispatch_tgt = stn_pkg::A_REPLY;
    end else begin
      dispatch_tgt = stn_pkg::A_STATUS;
    end
  end

  // Completion: the node has a parent and every expected reply is in; a non-root node does not hear from its parent.
  assign need_all = stn_pkg::count_ones(nb);
  assign need     = (!is_root && (need_all != '0)) ? need_all - 1'b1 : need_all;
  assign done_now = has_parent && (reply_count >= need);

  // A step that emits waits until the result slot is free.
  always_comb begin
    case (ctrl.emit)
      stn_pkg::E_NONE:      emit_need = 1'b0;
      stn_pkg::E_MSG:       emit_need = 1'b1;
      stn_pkg::E_STATUS:    emit_need = 1'b1;
      stn_pkg::E_PROBE_BIT: emit_need = pending[scan_idx];
      default:              emit_need = 1'b0;
    endcase
  end

  assign slot_free = !res_valid || res.ready;
  assign adv       = !emit_need || slot_free;

  // Outstanding probe set after this step.
  always_comb begin
    case (ctrl.upd)
      stn_pkg::U_START: pending_next = nb;
      stn_pkg::U_ADOPT: pending_next = nb & ~sbit;
      default: begin
        if (ctrl.emit == stn_pkg::E_PROBE_BIT) begin
          pending_next = pending & ~scan_bit;
        end else begin
          pending_next = pending;
        end
      end
    endcase
  end

  // Step counter sequencing.
  always_comb begin
    case (ctrl.cond)
      stn_pkg::C_ACCEPT:    upc_next = req.valid ? ctrl.tgt : ctrl.nxt;
      stn_pkg::C_ALWAYS:    upc_next = ctrl.tgt;
      stn_pkg::C_PEND_ZERO: upc_next = (pending_next == '0) ? ctrl.tgt : ctrl.nxt;
      stn_pkg::C_DISPATCH:  upc_next = dispatch_tgt;
      default:              upc_next = stn_pkg::A_WAIT;
    endcase
    if (!adv) begin
      upc_next = upc;
    end
  end

  assign req.ready   = (ctrl.cond == stn_pkg::C_ACCEPT);
  assign res.valid   = res_valid;
  assign res.payload = res_data;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id       <= '0;
      root_node     <= '0;
      neighbor_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        stn_pkg::CFG_NODE_ID: node_id       <= cfg_data[stn_pkg::NODE_W-1:0];
        stn_pkg::CFG_ROOT:    root_node     <= cfg_data[stn_pkg::NODE_W-1:0];
        stn_pkg::CFG_MASK:    neighbor_mask <= cfg_data[stn_pkg::NODES-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and node state.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc          <= stn_pkg::A_WAIT;
      has_parent   <= 1'b0;
      parent_reg   <= '0;
      child_bits   <= '0;
      nontree_bits <= '0;
      reply_count  <= '0;
    end else begin
      upc <= upc_next;
      if (adv) begin
        case (ctrl.upd)
          stn_pkg::U_START: begin
            has_parent <= 1'b1;
            parent_reg <= node_id;
          end
          stn_pkg::U_ADOPT: begin
            has_parent <= 1'b1;
            parent_reg <= cur.msg_sender;
          end
          stn_pkg::U_REPLY: begin
            if (cur.msg_kind == stn_pkg::KIND_ACK) begin
              child_bits <= child_bits | sbit;
            end else begin
              nontree_bits <= nontree_bits | sbit;
            end
            if (reply_count != '1) begin
              reply_count <= reply_count + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Held item and scan position.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cur <= req.payload;
    end
    if (adv) begin
      pending <= pending_next;
      if ((ctrl.upd == stn_pkg::U_START) || (ctrl.upd == stn_pkg::U_ADOPT)) begin
        scan_idx <= '0;
      end else if (ctrl.emit == stn_pkg::E_PROBE_BIT) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // Result slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && emit_need) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit_need) begin
      res_data.msg_valid    <= (ctrl.emit != stn_pkg::E_STATUS);
      res_data.out_kind     <= (ctrl.emit == stn_pkg::E_STATUS) ? stn_pkg::KIND_PROBE
                                                                : ctrl.kind;
      if (ctrl.emit == stn_pkg::E_STATUS) begin
        res_data.out_receiver <= '0;
      end else if (ctrl.emit == stn_pkg::E_PROBE_BIT) begin
        res_data.out_receiver <= scan_idx;
      end else begin
        res_data.out_receiver <= cur.msg_sender;
      end
      res_data.last         <= (ctrl.lsel == stn_pkg::L_ONE) || (pending_next == '0);
      res_data.tree_done    <= done_now;
      res_data.parent_index <= parent_reg;
      res_data.child_set    <= child_bits;
    end
  end

  // Checks on the sequencer and the node state.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (upc == stn_pkg::A_DISPATCH))
    else $error("accepted item did not move the sequencer to dispatch");

  a_parent_kept: assert property (@(posedge clk) disable iff (rst)
    has_parent |=> has_parent)
    else $error("parent lost without reset");

  a_sets_disjoint: assert property (@(posedge clk) disable iff (rst)
    ((child_bits & nontree_bits) == '0))
    else $error("node marked both child and non-tree");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (reply_count == stn_pkg::CNT_W'($countones(child_bits | nontree_bits))))
    else $error("reply count differs from recorded replies");

  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.last) |-> !req.ready)
    else $error("new item taken before the previous one finished");

endmodule
`default_nettype wire

// ===== test/tb_spanning_tree_node_probe_echo_top.sv =====
// Self-checking testbench for the spanning-tree node: directed table, then random traffic.
`default_nettype none
module tb_spanning_tree_node_probe_echo_top;

  // Message kind that no node ever sends; the block must ignore it.
  localparam logic [stn_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int DIR_ROWS    = 26;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 41;
  localparam int CALM_ITEMS  = 40;
  localparam int SETTLE_CYC  = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    stn_pkg::req_t              item;
    logic [stn_pkg::NODE_W-1:0] node;
    logic [stn_pkg::NODE_W-1:0] root;
    logic [stn_pkg::NODES-1:0]  mask;
    logic                       typed;
    stn_pkg::res_t              want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [stn_pkg::CIDX_W-1:0] cfg_index;
  logic [stn_pkg::CFG_W-1:0]  cfg_data;

  stn_req_if req_ch();
  stn_res_if res_ch();

  spanning_tree_node_probe_echo_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the node registers and state.
  logic [stn_pkg::NODE_W-1:0] sh_node, sh_root;
  logic [stn_pkg::NODES-1:0]  sh_mask;
  logic                       sh_has_parent;
  logic [stn_pkg::NODE_W-1:0] sh_parent;
  logic [stn_pkg::NODES-1:0]  sh_children, sh_nontree;
  logic [stn_pkg::CNT_W-1:0]  sh_replies;

  stn_pkg::res_t node_out_due[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   calm;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[spanning_tree_node_probe_echo_top] ERROR");
      $finish;
    end
  end

  function automatic logic [stn_pkg::NODES-1:0] neighbour_bits();
    return sh_mask & ~(stn_pkg::NODE_ONE << sh_node);
  endfunction

  // The node is done once it has a parent and every expected reply is in.
  function automatic logic tree_done_now();
    logic [stn_pkg::NODES-1:0] nb;
    int need;
    int j;
    nb = neighbour_bits();
    need = 0;
    for (j = 0; j < stn_pkg::NODES; j++) need += int'(nb[j]);
    if (!sh_has_parent) return 1'b0;
    if (sh_node != sh_root && need > 0) need--;
    return int'(sh_replies) >= need;
  endfunction

  // Advances the shadow state by one item and queues the outputs it causes.
  task automatic advance_tree_node(input stn_pkg::req_t r, input bit keep);
    logic [stn_pkg::NODES-1:0]  nb, sbit;
    logic                       is_root, from_parent;
    logic [stn_pkg::KIND_W-1:0] mk [0:6];
    logic [stn_pkg::NODE_W-1:0] mr [0:6];
    stn_pkg::res_t              e;
    int                         n, j;
    nb = neighbour_bits();
    sbit = stn_pkg::NODE_ONE << r.msg_sender;
    is_root = (sh_node == sh_root);
    n = 0;
    if (r.req_type == stn_pkg::REQ_START) begin
      if (is_root && !sh_has_parent) begin
        sh_has_parent = 1'b1;
        sh_parent = sh_node;
        for (j = 0; j < stn_pkg::NODES; j++) begin
          if (nb[j] && n < 7) begin
            mk[n] = stn_pkg::KIND_PROBE;
            mr[n] = stn_pkg::NODE_W'(j);
            n++;
          end
        end
      end
    end else if (r.msg_kind == stn_pkg::KIND_PROBE) begin
      if (r.msg_sender != sh_node && (nb & sbit) != '0) begin
        if (is_root || sh_has_parent) begin
          mk[0] = stn_pkg::KIND_REJECT;
          mr[0] = r.msg_sender;
          n = 1;
        end else begin
          // First probe: adopt the prober, ack it, then probe everyone else.
          sh_has_parent = 1'b1;
          sh_parent = r.msg_sender;
          mk[0] = stn_pkg::KIND_ACK;
          mr[0] = r.msg_sender;
          n = 1;
          for (j = 0; j < stn_pkg::NODES; j++) begin
            if (nb[j] && j != int'(r.msg_sender) && n < 7) begin
              mk[n] = stn_pkg::KIND_PROBE;
              mr[n] = stn_pkg::NODE_W'(j);
              n++;
            end
          end
        end
      end
    end else if (r.msg_kind == stn_pkg::KIND_ACK || r.msg_kind == stn_pkg::KIND_REJECT) begin
      from_parent = sh_has_parent && !is_root && r.msg_sender == sh_parent;
      if (r.msg_sender != sh_node && (nb & sbit) != '0 && !from_parent &&
          ((sh_children | sh_nontree) & sbit) == '0) begin
        if (r.msg_kind == stn_pkg::KIND_ACK) sh_children = sh_children | sbit;
        else sh_nontree = sh_nontree | sbit;
        if (sh_replies != '1) sh_replies = sh_replies + 1'b1;
      end
    end
    if (keep) begin
      e.tree_done = tree_done_now();
      e.parent_index = sh_parent;
      e.child_set = sh_children;
      if (n == 0) begin
        e.msg_valid = 1'b0;
        e.out_kind = stn_pkg::KIND_PROBE;
        e.out_receiver = '0;
        e.last = 1'b1;
        node_out_due.push_back(e);
      end
      for (j = 0; j < n; j++) begin
        e.msg_valid = 1'b1;
        e.out_kind = mk[j];
        e.out_receiver = mr[j];
        e.last = (j == n - 1);
        node_out_due.push_back(e);
      end
    end
  endtask

  // Table row builders.
  function automatic row_t cfg_row(input logic [stn_pkg::NODE_W-1:0] node,
                                   input logic [stn_pkg::NODE_W-1:0] root,
                                   input logic [stn_pkg::NODES-1:0] mask);
    row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.node = node;
    row.root = root;
    row.mask = mask;
    return row;
  endfunction

  function automatic row_t item_row(input logic rt, input logic [stn_pkg::KIND_W-1:0] kind,
                                    input logic [stn_pkg::NODE_W-1:0] sender);
    row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item.req_type = rt;
    row.item.msg_kind = kind;
    row.item.msg_sender = sender;
    return row;
  endfunction

  // A row whose single status-only output is written out by hand.
  function automatic row_t status_row(input logic rt, input logic [stn_pkg::KIND_W-1:0] kind,
                                      input logic [stn_pkg::NODE_W-1:0] sender,
                                      input logic done,
                                      input logic [stn_pkg::NODE_W-1:0] parent,
                                      input logic [stn_pkg::NODES-1:0] kids);
    row_t row;
    row = item_row(rt, kind, sender);
    row.typed = 1'b1;
    row.want.msg_valid = 1'b0;
    row.want.out_kind = stn_pkg::KIND_PROBE;
    row.want.out_receiver = '0;
    row.want.last = 1'b1;
    row.want.tree_done = done;
    row.want.parent_index = parent;
    row.want.child_set = kids;
    return row;
  endfunction

  // Directed table. Node 3 with neighbours 1, 2, 4, 5 and 7 (own bit set in the mask).
  function automatic row_t directed_row(input int i);
    row_t row;
    case (i)
      0:  row = cfg_row(3'd3, 3'd0, 8'hBE);
      // Start on a node that is not the root.
      1:  row = status_row(stn_pkg::REQ_START, stn_pkg::KIND_PROBE, 3'd0, 1'b0, 3'd0, 8'h00);
      // Probe from itself, then from a node that is not a neighbour.
      2:  row = status_row(stn_pkg::REQ_MSG, stn_pkg::KIND_PROBE, 3'd3, 1'b0, 3'd0, 8'h00);
      3:  row = status_row(stn_pkg::REQ_MSG, stn_pkg::KIND_PROBE, 3'd6, 1'b0, 3'd0, 8'h00);
      4:  row = status_row(stn_pkg::REQ_MSG, KIND_UNUSED, 3'd1, 1'b0, 3'd0, 8'h00);
      5:  row = status_row(stn_pkg::REQ_MSG, stn_pkg::KIND_ACK, 3'd0, 1'b0, 3'd0, 8'h00);
      // Replies before a parent is known still count; a repeat does not.
      6:  row = status_row(stn_pkg::REQ_MSG, stn_pkg::KIND_ACK, 3'd7, 1'b0, 3'd0, 8'h80);
      7:  row = status_row(stn_pkg::REQ_MSG, stn_pkg::KIND_REJECT, 3'd5, 1'b0, 3'd0, 8'h80);
      8:  row = status_row(stn_pkg::REQ_MSG, stn_pkg::KIND_ACK, 3'd7, 1'b0, 3'd0, 8'h80);
      // Adoption: ack to 2, probes to 1, 4, 5, 7.
      9:  row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_PROBE, 3'd2);
      10: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_PROBE, 3'd4);
      11: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_ACK, 3'd2);
      12: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_ACK, 3'd1);
      13: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_REJECT, 3'd4);
      14: row = item_row(stn_pkg::REQ_START, KIND_UNUSED, 3'd7);
      // Same node made root: probes rejected, start ignored, parent replies count.
      15: row = cfg_row(3'd3, 3'd3, 8'hBE);
      16: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_PROBE, 3'd1);
      17: row = item_row(stn_pkg::REQ_START, stn_pkg::KIND_PROBE, 3'd0);
      18: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_ACK, 3'd2);
      19: row = cfg_row(3'd0, 3'd0, 8'hFF);
      20: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_PROBE, 3'd7);
      21: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_ACK, 3'd6);
      22: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_PROBE, 3'd0);
      23: row = cfg_row(3'd7, 3'd7, 8'h00);
      24: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_PROBE, 3'd0);
      default: row = item_row(stn_pkg::REQ_MSG, stn_pkg::KIND_REJECT, 3'd0);
    endcase
    return row;
  endfunction

  // Mostly replies and probes from real neighbours, with some starts and noise.
  function automatic stn_pkg::req_t random_item();
    stn_pkg::req_t it;
    logic [stn_pkg::NODES-1:0] nb;
    int roll;
    nb = neighbour_bits();
    roll = $urandom_range(0, 99);
    it.req_type = stn_pkg::REQ_MSG;
    it.msg_kind = stn_pkg::KIND_W'($urandom_range(0, 3));
    it.msg_sender = stn_pkg::NODE_W'($urandom_range(0, stn_pkg::NODES - 1));
    if (roll < 8) begin
      it.req_type = stn_pkg::REQ_START;
    end else if (roll >= 22) begin
      if (nb != '0) begin
        while (!nb[it.msg_sender]) begin
          it.msg_sender = stn_pkg::NODE_W'($urandom_range(0, stn_pkg::NODES - 1));
        end
      end
      roll = $urandom_range(0, 9);
      it.msg_kind = (roll < 4) ? stn_pkg::KIND_PROBE :
                    (roll < 7) ? stn_pkg::KIND_ACK : stn_pkg::KIND_REJECT;
    end
    return it;
  endfunction

  // Offers one item, predicts at acceptance, then maybe leaves a gap.
  task automatic send_item(input stn_pkg::req_t it, input bit keep);
    req_ch.payload <= it;
    req_ch.valid <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    advance_tree_node(it, keep);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Waits until every expected output is in and the block has gone quiet.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (node_out_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_config(input logic [stn_pkg::NODE_W-1:0] node,
                              input logic [stn_pkg::NODE_W-1:0] root,
                              input logic [stn_pkg::NODES-1:0] mask);
    cfg_we <= 1'b1;
    cfg_index <= stn_pkg::CFG_NODE_ID;
    cfg_data <= stn_pkg::CFG_W'(node);
    @(posedge clk);
    cfg_index <= stn_pkg::CFG_ROOT;
    cfg_data <= stn_pkg::CFG_W'(root);
    @(posedge clk);
    cfg_index <= stn_pkg::CFG_MASK;
    cfg_data <= stn_pkg::CFG_W'(mask);
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_node = node;
    sh_root = root;
    sh_mask = mask;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Output side: random stalls in bursts, none near the end.
  initial begin : result_stall
    int hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) res_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        res_ch.ready <= 1'b0;
        hold = $urandom_range(1, 12);
      end
    end
  end

  // Compare each accepted output item with the oldest expectation.
  always @(posedge clk) begin : result_check
    stn_pkg::res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (node_out_due.size() == 0) begin
        $error("output item with nothing expected: %h", res_ch.payload);
        mismatch_count++;
      end else begin
        want = node_out_due.pop_front();
        check_field("msg_valid", 32'(want.msg_valid), 32'(res_ch.payload.msg_valid));
        check_field("out_kind", 32'(want.out_kind), 32'(res_ch.payload.out_kind));
        check_field("out_receiver", 32'(want.out_receiver),
                    32'(res_ch.payload.out_receiver));
        check_field("last", 32'(want.last), 32'(res_ch.payload.last));
        check_field("tree_done", 32'(want.tree_done), 32'(res_ch.payload.tree_done));
        check_field("parent_index", 32'(want.parent_index),
                    32'(res_ch.payload.parent_index));
        check_field("child_set", 32'(want.child_set), 32'(res_ch.payload.child_set));
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    row_t row;
    int i, p, k, sent;
    logic [stn_pkg::NODE_W-1:0] node, root;
    logic [stn_pkg::NODES-1:0] mask;
    calm = 1'b0;
    sent = 0;
    sh_node = '0;
    sh_root = '0;
    sh_mask = '0;
    sh_has_parent = 1'b0;
    sh_parent = '0;
    sh_children = '0;
    sh_nontree = '0;
    sh_replies = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= stn_pkg::CFG_NODE_ID;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      row = directed_row(i);
      if (row.kind == ROW_CFG) begin
        settle();
        write_config(row.node, row.root, row.mask);
      end else begin
        // A hand-written expectation is queued before the item can be answered.
        if (row.typed) node_out_due.push_back(row.want);
        send_item(row.item, !row.typed);
      end
    end

    // Random phases; the first two use the register extremes.
    for (p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        node = 3'd0;
        root = 3'd7;
        mask = 8'hFF;
      end else if (p == 1) begin
        node = 3'd7;
        root = 3'd0;
        mask = 8'h00;
      end else begin
        node = stn_pkg::NODE_W'($urandom_range(0, stn_pkg::NODES - 1));
        root = ($urandom_range(0, 1) == 0) ? node :
               stn_pkg::NODE_W'($urandom_range(0, stn_pkg::NODES - 1));
        mask = stn_pkg::NODES'($urandom_range(0, 255));
      end
      settle();
      write_config(node, root, mask);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        calm = (sent >= PHASES * PHASE_ITEMS - CALM_ITEMS);
        send_item(random_item(), 1'b1);
        sent++;
      end
    end

    settle();
    if (mismatch_count == 0 && node_out_due.size() == 0) begin
      $display("[spanning_tree_node_probe_echo_top] OK");
    end else begin
      $display("[spanning_tree_node_probe_echo_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/stn_pkg.sv
sv/stn_req_if.sv
sv/stn_res_if.sv
sv/spanning_tree_node_probe_echo_top.sv
test/tb_spanning_tree_node_probe_echo_top.sv
